>>> rtl/diff_drive_command_controller_assert.svh
// ----------------------------------------------------------------------------
// diff drive command controller assertion macros
// shared concurrent assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_COMMAND_CONTROLLER_ASSERT_SVH
`define DIFF_DRIVE_COMMAND_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DDCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, checked out of reset
`define DDCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/ddcc_pkg.sv
// ----------------------------------------------------------------------------
// ddcc_pkg
// types, codes and duty arithmetic for the diff drive command controller
// ----------------------------------------------------------------------------
package ddcc_pkg;

    localparam int LEVEL_W   = 10;
    localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;
    localparam int DUTY_W    = 8;
    localparam int DUTY_FULL = 250;
    localparam int PROD_W    = LEVEL_W + DUTY_W;
    localparam int CFG_IDX_W = 2;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [DUTY_W-1:0]  duty_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_AUTO   = 2'd2,
        MODE_SEMI   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE     = 2'd0,
        CFG_STRAIGHT_INIT = 2'd1,
        CFG_TURN_SLOW     = 2'd2,
        CFG_TURN_FAST     = 2'd3
    } cfg_idx_t;

    // move codes
    localparam logic [2:0] MOVE_STOP  = 3'd0;
    localparam logic [2:0] MOVE_FWD   = 3'd1;
    localparam logic [2:0] MOVE_BACK  = 3'd2;
    localparam logic [2:0] MOVE_LEFT  = 3'd3;
    localparam logic [2:0] MOVE_RIGHT = 3'd4;

    // pending adjustment codes
    localparam logic [2:0] ADJ_NONE = 3'd0;
    localparam logic [2:0] ADJ_UP1  = 3'd1;
    localparam logic [2:0] ADJ_DN1  = 3'd2;
    localparam logic [2:0] ADJ_UP2  = 3'd3;
    localparam logic [2:0] ADJ_DN2  = 3'd4;

    // command characters
    localparam logic [7:0] CH_M_LO = 8'h6D;
    localparam logic [7:0] CH_M_UP = 8'h4D;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_S_LO = 8'h73;
    localparam logic [7:0] CH_S_UP = 8'h53;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_5    = 8'h35;
    localparam logic [7:0] CH_8    = 8'h38;

    // bridge pin patterns
    localparam logic [3:0] PINS_BRAKE = 4'h0;
    localparam logic [3:0] PINS_FWD   = 4'h5;
    localparam logic [3:0] PINS_BACK  = 4'hA;

    // lamp patterns, bit0 manual, bit1 auto, bit2 warn
    localparam logic [2:0] LAMP_MANUAL = 3'b001;
    localparam logic [2:0] LAMP_AUTO   = 3'b010;
    localparam int         LAMP_WARN   = 2;

    typedef struct packed {
        level_t step_size;
        level_t straight_init;
        level_t turn_slow;
        level_t turn_fast;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [2:0] move;
        logic [2:0] pending;
        logic       blocked;
        level_t     straight;
        level_t     first;
        level_t     second;
        logic [2:0] flags;     // bit0 straight, bit1 left turn, bit2 right turn
        logic [3:0] pins;
        duty_t      duty_a;
        duty_t      duty_b;
        logic [2:0] lamps;
    } state_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
        logic [3:0] sensor_bits;
    } item_t;

    // packed lowest field last, so bridge_pins lands in bit 0
    typedef struct packed {
        logic       led_warn;
        logic       led_auto;
        logic       led_manual;
        logic       obstacle;
        logic [1:0] mode_now;
        duty_t      right_duty;
        duty_t      left_duty;
        logic [3:0] bridge_pins;
    } result_t;

    localparam int RES_W   = $bits(result_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    // floor(lvl * 250 / LEVEL_MAX); LEVEL_MAX is 2^W-1 so x/2^W plus one correction
    function automatic duty_t duty_of(input level_t lvl);
        logic [PROD_W-1:0]  prod;
        logic [DUTY_W-1:0]  q0;
        logic [LEVEL_W:0]   rem;
        prod = PROD_W'(lvl) * PROD_W'(DUTY_FULL);
        q0   = prod[PROD_W-1:LEVEL_W];
        rem  = {1'b0, prod[LEVEL_W-1:0]} + (LEVEL_W+1)'(q0);
        if (rem >= (LEVEL_W+1)'(LEVEL_MAX))
            return q0 + DUTY_W'(1);
        else
            return q0;
    endfunction

    function automatic level_t sat_add(input level_t a, input level_t b);
        logic [LEVEL_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum > (LEVEL_W+1)'(LEVEL_MAX))
            return level_t'(LEVEL_MAX);
        else
            return sum[LEVEL_W-1:0];
    endfunction

    function automatic level_t sat_sub(input level_t a, input level_t b);
        if (a < b)
            return '0;
        else
            return a - b;
    endfunction

endpackage

>>> rtl/ddcc_core.sv
// ----------------------------------------------------------------------------
// ddcc_core
// next-state logic for one item: decode, manual drive loop, duty counts
// ----------------------------------------------------------------------------
module ddcc_core (
    input  ddcc_pkg::state_t cur,
    input  ddcc_pkg::item_t  item,
    input  ddcc_pkg::cfg_t   cfg,
    output ddcc_pkg::state_t nxt
);
    import ddcc_pkg::*;

    logic             up;
    logic             lvl1;
    logic [LEVEL_W:0] raw_first;
    logic [LEVEL_W:0] raw_second;
    level_t           src_a;
    level_t           src_b;
    duty_t            duty_a_new;
    duty_t            duty_b_new;

    always_comb
    begin
        nxt        = cur;
        up         = 1'b0;
        lvl1       = 1'b0;
        raw_first  = '0;
        raw_second = '0;
        src_a      = '0;
        src_b      = '0;
        duty_a_new = '0;
        duty_b_new = '0;

        // decode the item
        if (!item.opcode)
        begin
            if (item.rx_byte == CH_M_LO || item.rx_byte == CH_M_UP)
                nxt.mode = MODE_MANUAL;
            else if (item.rx_byte == CH_A_LO || item.rx_byte == CH_A_UP)
                nxt.mode = MODE_AUTO;
            else if (item.rx_byte == CH_S_LO || item.rx_byte == CH_S_UP)
                nxt.mode = MODE_SEMI;
            else if (item.rx_byte >= CH_0 && item.rx_byte <= CH_4)
                nxt.move = 3'(item.rx_byte - CH_0);
            else if (item.rx_byte >= CH_5 && item.rx_byte <= CH_8)
                nxt.pending = 3'(item.rx_byte - CH_4);
        end
        else
        begin
            nxt.blocked = (item.sensor_bits == 4'd0);
        end

        if (nxt.mode == MODE_MANUAL || nxt.mode == MODE_AUTO)
        begin
            if (nxt.blocked)
            begin
                nxt.lamps[LAMP_WARN] = 1'b1;
                nxt.pins             = PINS_BRAKE;
            end
            else if (nxt.mode == MODE_AUTO)
            begin
                nxt.lamps = LAMP_AUTO;
                nxt.pins  = PINS_BRAKE;
            end
            else
            begin
                nxt.lamps = LAMP_MANUAL;

                // first-use level loads
                unique case (nxt.move)
                    MOVE_FWD, MOVE_BACK:
                    begin
                        if (!nxt.flags[0])
                        begin
                            nxt.straight = cfg.straight_init;
                            nxt.flags[0] = 1'b1;
                        end
                    end
                    MOVE_LEFT:
                    begin
                        if (!nxt.flags[1])
                        begin
                            nxt.first    = cfg.turn_slow;
                            nxt.second   = cfg.turn_fast;
                            nxt.flags[1] = 1'b1;
                        end
                        nxt.flags[2] = 1'b0;
                    end
                    MOVE_RIGHT:
                    begin
                        if (!nxt.flags[2])
                        begin
                            nxt.second   = cfg.turn_slow;
                            nxt.first    = cfg.turn_fast;
                            nxt.flags[2] = 1'b1;
                        end
                        nxt.flags[1] = 1'b0;
                    end
                    default: ;
                endcase

                // pending adjustment, consumed whatever the move
                if (nxt.pending != ADJ_NONE)
                begin
                    up          = (nxt.pending == ADJ_UP1) || (nxt.pending == ADJ_UP2);
                    lvl1        = (nxt.pending == ADJ_UP1) || (nxt.pending == ADJ_DN1);
                    nxt.pending = ADJ_NONE;
                    raw_first   = {1'b0, nxt.first} + {1'b0, cfg.step_size};
                    raw_second  = {1'b0, nxt.second} + {1'b0, cfg.step_size};

                    unique case (nxt.move)
                        MOVE_FWD, MOVE_BACK:
                        begin
                            nxt.straight = up ? sat_add(nxt.straight, cfg.step_size)
                                              : sat_sub(nxt.straight, cfg.step_size);
                        end
                        MOVE_LEFT:
                        begin
                            // a step that would take the inner wheel level up to the outer wheel level is not taken
                            if (lvl1 && up)
                            begin
                                if (raw_first < {1'b0, nxt.second})
                                    nxt.first = raw_first[LEVEL_W-1:0];
                            end
                            else if (lvl1)
                                nxt.first = sat_sub(nxt.first, cfg.step_size);
                            else if (up)
                                nxt.second = sat_add(nxt.second, cfg.step_size);
                            else if (nxt.second >= cfg.step_size &&
                                     (nxt.second - cfg.step_size) > nxt.first)
                                nxt.second = nxt.second - cfg.step_size;
                        end
                        MOVE_RIGHT:
                        begin
                            if (lvl1 && up)
                                nxt.first = sat_add(nxt.first, cfg.step_size);
                            else if (lvl1)
                            begin
                                if (nxt.first >= cfg.step_size &&
                                    (nxt.first - cfg.step_size) > nxt.second)
                                    nxt.first = nxt.first - cfg.step_size;
                            end
                            else if (up)
                            begin
                                if (raw_second < {1'b0, nxt.first})
                                    nxt.second = raw_second[LEVEL_W-1:0];
                            end
                            else
                                nxt.second = sat_sub(nxt.second, cfg.step_size);
                        end
                        default: ;
                    endcase
                end

                // duties from the settled levels
                if (nxt.move == MOVE_FWD || nxt.move == MOVE_BACK)
                begin
                    src_a = nxt.straight;
                    src_b = nxt.straight;
                end
                else
                begin
                    src_a = nxt.first;
                    src_b = nxt.second;
                end
                duty_a_new = duty_of(src_a);
                duty_b_new = duty_of(src_b);

                unique case (nxt.move)
                    MOVE_FWD:
                    begin
                        nxt.pins   = PINS_FWD;
                        nxt.duty_a = duty_a_new;
                        nxt.duty_b = duty_b_new;
                    end
                    MOVE_BACK:
                    begin
                        nxt.pins   = PINS_BACK;
                        nxt.duty_a = duty_a_new;
                        nxt.duty_b = duty_b_new;
                    end
                    MOVE_LEFT, MOVE_RIGHT:
                    begin
                        nxt.pins   = PINS_FWD;
                        nxt.duty_a = duty_a_new;
                        nxt.duty_b = duty_b_new;
                    end
                    default: nxt.pins = PINS_BRAKE;
                endcase
            end
        end
    end

endmodule

>>> rtl/diff_drive_command_controller.sv
// ----------------------------------------------------------------------------
// diff_drive_command_controller
// command byte and presence sensor handling for a two-wheel drive
// ----------------------------------------------------------------------------
//
//  channel      dir  transfer content
//  s_axis       in   tdata: rx_byte, sensor_bits; tuser: opcode
//  m_axis       out  tdata: pins, duties, mode, obstacle, lamps
//  cfg          in   write of step size and the three first-use levels
//
//  one item per cycle sustained when the output side does not stall: an
//  input register, one stage of update logic and an output register; an
//  item passes from the input register through the update logic into the
//  result register, whose contents are valid on m_axis
//  reset clears all drive state and loads the register defaults
//  an output stall holds the result register, and the input register takes
//  one more item before s_axis_tready drops
//
module diff_drive_command_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] rx_byte, [11:8] sensor_bits, [15:12] zero
    input  logic [15:0]                           s_axis_tdata,
    // [0] opcode
    input  logic [0:0]                            s_axis_tuser,

    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [3:0] bridge_pins, [11:4] left_duty, [19:12] right_duty,
    // [21:20] mode_now, [22] obstacle, [23] led_manual, [24] led_auto,
    // [25] led_warn, upper bits zero
    output logic [ddcc_pkg::TDATA_W-1:0]          m_axis_tdata,

    input  logic                                  cfg_we,
    input  logic [ddcc_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [ddcc_pkg::LEVEL_W-1:0]          cfg_wdata
);
    import ddcc_pkg::*;

    `include "diff_drive_command_controller_assert.svh"

    // input stage
    logic    in_valid_reg;
    item_t   in_item_reg;

    // drive state and registers
    state_t  st_reg;
    state_t  st_next;
    cfg_t    cfg_reg;

    // result stage
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;
    result_t out_res_next;

    logic    advance;
    logic    in_xfer;

    // the update stage fires when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg.opcode      <= s_axis_tuser[0];
            in_item_reg.rx_byte     <= s_axis_tdata[7:0];
            in_item_reg.sensor_bits <= s_axis_tdata[11:8];
        end
    end

    // configuration writes; the user issues them only while the block is idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size     <= level_t'(100);
            cfg_reg.straight_init <= level_t'(511);
            cfg_reg.turn_slow     <= level_t'(256);
            cfg_reg.turn_fast     <= level_t'(767);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_STEP_SIZE:     cfg_reg.step_size     <= cfg_wdata;
                CFG_STRAIGHT_INIT: cfg_reg.straight_init <= cfg_wdata;
                CFG_TURN_SLOW:     cfg_reg.turn_slow     <= cfg_wdata;
                CFG_TURN_FAST:     cfg_reg.turn_fast     <= cfg_wdata;
            endcase
        end
    end

    // decode, drive loop and duty arithmetic
    ddcc_core u_core (
        .cur  (st_reg),
        .item (in_item_reg),
        .cfg  (cfg_reg),
        .nxt  (st_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (advance)
            st_reg <= st_next;
    end

    // result fields from the state just computed
    always_comb
    begin
        out_res_next.bridge_pins = st_next.pins;
        out_res_next.left_duty   = st_next.duty_a;
        out_res_next.right_duty  = st_next.duty_b;
        out_res_next.mode_now    = 2'(st_next.mode);
        out_res_next.obstacle    = st_next.blocked;
        out_res_next.led_manual  = st_next.lamps[0];
        out_res_next.led_auto    = st_next.lamps[1];
        out_res_next.led_warn    = st_next.lamps[LAMP_WARN];
    end

    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(TDATA_W - RES_W)'(0), out_res_reg};

    // checks

    // only brake, forward and reverse patterns reach the bridge
    `DDCC_ASSERT_IMP(a_pins_legal, clk, rst_n, m_axis_tvalid,
        out_res_reg.bridge_pins == PINS_BRAKE || out_res_reg.bridge_pins == PINS_FWD ||
        out_res_reg.bridge_pins == PINS_BACK)

    // an obstacle in manual or automatic mode always brakes
    `DDCC_ASSERT_IMP(a_obstacle_brakes, clk, rst_n,
        m_axis_tvalid && out_res_reg.obstacle &&
        (out_res_reg.mode_now == 2'(MODE_MANUAL) || out_res_reg.mode_now == 2'(MODE_AUTO)),
        out_res_reg.bridge_pins == PINS_BRAKE && out_res_reg.led_warn)

    // duty counts never pass full scale
    `DDCC_ASSERT_IMP(a_duty_range, clk, rst_n, m_axis_tvalid,
        out_res_reg.left_duty <= DUTY_W'(DUTY_FULL) &&
        out_res_reg.right_duty <= DUTY_W'(DUTY_FULL))

    // a processed item always leaves a result behind
    `DDCC_ASSERT_NXT(a_advance_result, clk, rst_n, advance, m_axis_tvalid)

endmodule

>>> bench/ddcc_tb_pkg.sv
// ----------------------------------------------------------------------------
// ddcc_tb_pkg
// scoreboard for the diff drive command controller bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddcc_tb_pkg;

    import ddcc_pkg::*;

    // tuser codes
    localparam logic OP_CMD    = 1'b0;
    localparam logic OP_SENSOR = 1'b1;

    // first-use flag bits
    localparam int FLAG_STRAIGHT = 0;
    localparam int FLAG_LEFT     = 1;
    localparam int FLAG_RIGHT    = 2;

    class drive_scoreboard;

        // register copies
        int unsigned step_size;
        int unsigned straight_init;
        int unsigned turn_slow;
        int unsigned turn_fast;

        // drive state
        mode_t       mode;
        logic [2:0]  move;
        logic [2:0]  pending;
        bit          blocked;
        int          straight;
        int          first;
        int          second;
        logic [2:0]  flags;
        logic [3:0]  pins;
        duty_t       duty_a;
        duty_t       duty_b;
        logic [2:0]  lamps;

        result_t     drive_results_due[$];
        int          errors;

        function new();
            step_size     = 100;
            straight_init = 511;
            turn_slow     = 256;
            turn_fast     = 767;
            mode     = MODE_IDLE;
            move     = MOVE_STOP;
            pending  = ADJ_NONE;
            blocked  = 1'b0;
            straight = 0;
            first    = 0;
            second   = 0;
            flags    = '0;
            pins     = PINS_BRAKE;
            duty_a   = '0;
            duty_b   = '0;
            lamps    = '0;
            errors   = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, level_t value);
            case (idx)
                CFG_STEP_SIZE:     step_size     = value;
                CFG_STRAIGHT_INIT: straight_init = value;
                CFG_TURN_SLOW:     turn_slow     = value;
                CFG_TURN_FAST:     turn_fast     = value;
                default: ;
            endcase
        endfunction

        function int clamp_level(int v);
            if (v < 0)
                return 0;
            if (v > LEVEL_MAX)
                return LEVEL_MAX;
            return v;
        endfunction

        function duty_t level_to_duty(int lvl);
            int unsigned l;
            l = clamp_level(lvl);
            return duty_t'((l * DUTY_FULL) / LEVEL_MAX);
        endfunction

        function void apply_move();
            case (move)
                MOVE_FWD, MOVE_BACK:
                begin
                    if (!flags[FLAG_STRAIGHT])
                    begin
                        straight = clamp_level(straight_init);
                        flags[FLAG_STRAIGHT] = 1'b1;
                    end
                    duty_a = level_to_duty(straight);
                    duty_b = level_to_duty(straight);
                    pins   = (move == MOVE_FWD) ? PINS_FWD : PINS_BACK;
                end
                MOVE_LEFT:
                begin
                    if (!flags[FLAG_LEFT])
                    begin
                        first  = clamp_level(turn_slow);
                        second = clamp_level(turn_fast);
                        flags[FLAG_LEFT] = 1'b1;
                    end
                    flags[FLAG_RIGHT] = 1'b0;
                    duty_a = level_to_duty(first);
                    duty_b = level_to_duty(second);
                    pins   = PINS_FWD;
                end
                MOVE_RIGHT:
                begin
                    if (!flags[FLAG_RIGHT])
                    begin
                        second = clamp_level(turn_slow);
                        first  = clamp_level(turn_fast);
                        flags[FLAG_RIGHT] = 1'b1;
                    end
                    flags[FLAG_LEFT] = 1'b0;
                    duty_a = level_to_duty(first);
                    duty_b = level_to_duty(second);
                    pins   = PINS_FWD;
                end
                default: pins = PINS_BRAKE;
            endcase
        endfunction

        // turn steps that would swap the inner and outer wheel are dropped
        function void apply_adjust();
            int st;
            bit up;
            bit on_first;
            int v;
            if (pending == ADJ_NONE || pending > ADJ_DN2)
                return;
            st       = step_size;
            up       = (pending == ADJ_UP1 || pending == ADJ_UP2);
            on_first = (pending == ADJ_UP1 || pending == ADJ_DN1);
            pending  = ADJ_NONE;
            if (move == MOVE_FWD || move == MOVE_BACK)
                straight = clamp_level(straight + (up ? st : -st));
            else if (move == MOVE_LEFT)
            begin
                if (on_first && up)
                begin
                    v = first + st;
                    if (v < second)
                        first = clamp_level(v);
                end
                else if (on_first)
                    first = clamp_level(first - st);
                else if (up)
                    second = clamp_level(second + st);
                else
                begin
                    v = second - st;
                    if (v > first)
                        second = clamp_level(v);
                end
            end
            else if (move == MOVE_RIGHT)
            begin
                if (on_first && up)
                    first = clamp_level(first + st);
                else if (on_first)
                begin
                    v = first - st;
                    if (v > second)
                        first = clamp_level(v);
                end
                else if (up)
                begin
                    v = second + st;
                    if (v < first)
                        second = clamp_level(v);
                end
                else
                    second = clamp_level(second - st);
            end
        endfunction

        function void decode_byte(logic [7:0] b);
            if (b == CH_M_LO || b == CH_M_UP)
                mode = MODE_MANUAL;
            else if (b == CH_A_LO || b == CH_A_UP)
                mode = MODE_AUTO;
            else if (b == CH_S_LO || b == CH_S_UP)
                mode = MODE_SEMI;
            else if (b >= CH_0 && b <= CH_4)
                move = 3'(b - CH_0);
            else if (b >= CH_5 && b <= CH_8)
                pending = ADJ_UP1 + 3'(b - CH_5);
        endfunction

        // one accepted command or sensor update, one drive output expected
        function void note_command(item_t it);
            result_t r;
            if (it.opcode == OP_CMD)
                decode_byte(it.rx_byte);
            else
                blocked = (it.sensor_bits == 4'h0);

            if (mode == MODE_MANUAL || mode == MODE_AUTO)
            begin
                if (blocked)
                begin
                    lamps[LAMP_WARN] = 1'b1;
                    pins = PINS_BRAKE;
                end
                else if (mode == MODE_MANUAL)
                begin
                    lamps = LAMP_MANUAL;
                    apply_move();
                    apply_adjust();
                    apply_move();
                end
                else
                begin
                    lamps = LAMP_AUTO;
                    pins  = PINS_BRAKE;
                end
            end

            r.bridge_pins = pins;
            r.left_duty   = duty_a;
            r.right_duty  = duty_b;
            r.mode_now    = mode;
            r.obstacle    = blocked;
            r.led_manual  = lamps[0];
            r.led_auto    = lamps[1];
            r.led_warn    = lamps[LAMP_WARN];
            drive_results_due.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_drive_output(result_t got);
            result_t want;
            if (drive_results_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output, expected none, actual %h", $time, got);
                return;
            end
            want = drive_results_due.pop_front();
            compare_field("bridge_pins", want.bridge_pins, got.bridge_pins);
            compare_field("left_duty",   want.left_duty,   got.left_duty);
            compare_field("right_duty",  want.right_duty,  got.right_duty);
            compare_field("mode_now",    want.mode_now,    got.mode_now);
            compare_field("obstacle",    want.obstacle,    got.obstacle);
            compare_field("led_manual",  want.led_manual,  got.led_manual);
            compare_field("led_auto",    want.led_auto,    got.led_auto);
            compare_field("led_warn",    want.led_warn,    got.led_warn);
        endfunction

    endclass

endpackage

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives command bytes and sensor updates into the drive controller, runs
// several register settings and idle patterns, and checks every output
// transfer against a cycle-free model of the drive state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import ddcc_pkg::*;
    import ddcc_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 180;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] rx_byte, [11:8] sensor_bits, [15:12] zero
    logic [15:0]           s_axis_tdata  = '0;
    // [0] opcode
    logic [0:0]            s_axis_tuser  = '0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [3:0] bridge_pins, [11:4] left_duty, [19:12] right_duty, [21:20] mode_now,
    // [22] obstacle, [23] led_manual, [24] led_auto, [25] led_warn
    logic [TDATA_W-1:0]    m_axis_tdata;

    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr      = '0;
    logic [LEVEL_W-1:0]    cfg_wdata     = '0;

    // idle percentages for each side, changed between phases
    int unsigned           send_idle_pct = 0;
    int unsigned           recv_idle_pct = 0;
    int unsigned           cycle_count   = 0;

    drive_scoreboard       sb = new();

    diff_drive_command_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 clk = ~clk;

    // run guard, counts from time zero
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("diff_drive_command_controller regression: fail");
            $finish;
        end
    end

    // receiver side back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // output monitor: values read here are the ones present at the edge
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_drive_output(result_t'(m_axis_tdata[RES_W-1:0]));

    // present one item and hold it until the transfer happens
    task automatic send_item(item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, it.sensor_bits, it.rx_byte};
        s_axis_tuser  <= it.opcode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        item_t it;
        it.opcode      = OP_CMD;
        it.rx_byte     = b;
        it.sensor_bits = 4'($urandom_range(15));
        send_item(it);
    endtask

    task automatic send_sensor(logic [3:0] s);
        item_t it;
        it.opcode      = OP_SENSOR;
        it.rx_byte     = 8'($urandom_range(255));
        it.sensor_bits = s;
        send_item(it);
    endtask

    task automatic send_move(logic [2:0] m);
        send_byte(CH_0 + 8'(m));
    endtask

    task automatic send_adjust(logic [2:0] a);
        send_byte(CH_5 + 8'(a - ADJ_UP1));
    endtask

    // sender holds off until the output side has caught up
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.drive_results_due.size() != 0);
    endtask

    // register writes, only issued with nothing in flight
    task automatic write_settings(cfg_t c);
        cfg_idx_t idx[4];
        level_t   val[4];
        idx = '{CFG_STEP_SIZE, CFG_STRAIGHT_INIT, CFG_TURN_SLOW, CFG_TURN_FAST};
        val = '{c.step_size, c.straight_init, c.turn_slow, c.turn_fast};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly manual-mode traffic so moves and adjustments keep happening;
    // the rest is mode changes, obstacles and junk bytes
    function automatic item_t pick_command();
        item_t       it;
        int unsigned r;
        int unsigned k;
        it.opcode      = OP_CMD;
        it.rx_byte     = 8'($urandom_range(255));
        it.sensor_bits = 4'($urandom_range(15));
        r = $urandom_range(99);
        if (r < 40)
            it.rx_byte = CH_0 + 8'($urandom_range(4));
        else if (r < 65)
            it.rx_byte = CH_5 + 8'($urandom_range(3));
        else if (r < 75)
        begin
            k = $urandom_range(9);
            if (k < 6)
                it.rx_byte = $urandom_range(1) ? CH_M_LO : CH_M_UP;
            else if (k < 8)
                it.rx_byte = $urandom_range(1) ? CH_A_LO : CH_A_UP;
            else
                it.rx_byte = $urandom_range(1) ? CH_S_LO : CH_S_UP;
        end
        else if (r < 87)
        begin
            it.opcode = OP_SENSOR;
            if ($urandom_range(2) == 0)
                it.sensor_bits = 4'h0;
        end
        return it;
    endfunction

    initial
    begin
        cfg_t phase_cfg[PHASES];

        // extremes, reversed turn levels, zero step, then random and defaults
        phase_cfg[0] = '{step_size: 10'd1,    straight_init: 10'd1023,
                         turn_slow: 10'd0,    turn_fast: 10'd1023};
        phase_cfg[1] = '{step_size: 10'd1023, straight_init: 10'd0,
                         turn_slow: 10'd1023, turn_fast: 10'd0};
        phase_cfg[2] = '{step_size: 10'd0,    straight_init: 10'd512,
                         turn_slow: 10'd500,  turn_fast: 10'd510};
        phase_cfg[3] = '{step_size: 10'($urandom_range(300)),
                         straight_init: 10'($urandom_range(1023)),
                         turn_slow: 10'($urandom_range(1023)),
                         turn_fast: 10'($urandom_range(1023))};
        phase_cfg[4] = '{step_size: 10'($urandom_range(1023)),
                         straight_init: 10'($urandom_range(1023)),
                         turn_slow: 10'($urandom_range(511)),
                         turn_fast: 10'($urandom_range(1023, 512))};
        phase_cfg[5] = '{step_size: 10'd100,  straight_init: 10'd511,
                         turn_slow: 10'd256,  turn_fast: 10'd767};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part on reset register values
        send_move(MOVE_FWD);            // idle mode, nothing moves
        send_byte(CH_M_LO);
        send_move(MOVE_FWD);            // straight level loaded on first use
        send_adjust(ADJ_UP1);
        send_adjust(ADJ_DN1);
        send_move(MOVE_BACK);
        send_move(MOVE_LEFT);           // turn levels loaded
        send_adjust(ADJ_UP1);
        send_adjust(ADJ_DN2);
        send_adjust(ADJ_UP2);
        send_move(MOVE_RIGHT);          // left flag dropped, right levels loaded
        send_adjust(ADJ_DN1);
        send_adjust(ADJ_UP2);
        send_move(MOVE_STOP);           // brake, duties hold
        send_adjust(ADJ_UP1);           // consumed while stopped
        send_sensor(4'h0);              // obstacle brakes, warn lamp on
        send_adjust(ADJ_DN2);           // stays pending behind the obstacle
        send_byte(CH_A_UP);
        send_sensor(4'hF);              // clear, automatic mode only brakes
        send_byte(CH_S_UP);             // semi mode holds everything
        send_byte(8'hFF);               // unknown bytes change nothing
        send_byte(8'h00);
        send_byte(CH_M_UP);
        send_move(MOVE_LEFT);           // held adjustment was already consumed at the mode change while stopped
        send_byte(CH_S_LO);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_outputs();
            write_settings(phase_cfg[p]);
            // receiver-heavy idling, then sender-heavy, then none
            if (p < 2)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 55;
            end
            else if (p < 4)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(149) == 0)
                    drain_outputs();
                send_item(pick_command());
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.drive_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.drive_results_due.size() == 0)
            $display("diff_drive_command_controller regression: pass");
        else
            $display("diff_drive_command_controller regression: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/ddcc_pkg.sv
rtl/ddcc_core.sv
rtl/diff_drive_command_controller.sv
bench/ddcc_tb_pkg.sv
bench/testbench.sv
